/* src/aabb_collision_side_resolver_macros.svh */
// assertion macros shared by the rtl
`ifndef AABB_COLLISION_SIDE_RESOLVER_MACROS_SVH
`define AABB_COLLISION_SIDE_RESOLVER_MACROS_SVH

// antecedent holds in the same cycle as the consequent
`define AABB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define AABB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/aabb_csr_pkg.sv */
`timescale 1ns / 1ps

package aabb_csr_pkg;

   localparam int MAX_PLATFORMS = 64;
   localparam int COORD_WIDTH   = 16;
   localparam int IDX_W         = $clog2(MAX_PLATFORMS);
   localparam int CNT_W         = $clog2(MAX_PLATFORMS + 1);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [COORD_WIDTH:0]   ovl_type;

   typedef enum logic {
      MODE_LOAD  = 1'b0,
      MODE_QUERY = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      SIDE_NONE  = 3'd0,
      SIDE_LEFT  = 3'd1,
      SIDE_RIGHT = 3'd2,
      SIDE_UP    = 3'd3,
      SIDE_DOWN  = 3'd4
   } side_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      coord_type y;
      coord_type x;
   } corner_type;

   typedef struct packed {
      mode_type         mode;
      logic [5:0]       entry_index;
      logic signed [15:0] box_min_x;
      logic signed [15:0] box_min_y;
      logic signed [15:0] box_max_x;
      logic signed [15:0] box_max_y;
   } req_type;

   typedef struct packed {
      side_type    side;
      logic [15:0] overlap;
      logic [5:0]  hit_index;
   } rsp_type;

endpackage

/* src/aabb_collision_side_resolver.sv */
`timescale 1ns / 1ps
// aabb collision side resolver
// channels: start/busy with req_data takes one item; mode load writes one
// platform rectangle into slot entry_index of the corner memories, mode
// query scans slots 0 .. platform_count-1 for the first rectangle that
// overlaps the player box, the scan limit saturating at MAX_PLATFORMS.
// csr_we/csr_wdata writes platform_count, which the user is to write only
// while the block is idle; the block does not enforce this. a load gives
// no result; busy stays low. a query raises busy and gives exactly one
// result on rsp_data, marked by rsp_valid for one cycle. the scan reads
// one slot per cycle from the memory port, then a compare stage and a
// select stage follow: each slot read, its compare result and the
// selected side and overlap on rsp_data are registered in that order.
// the next item may be started in the cycle the result is shown.
// reset clears the control state and platform_count; the memory contents
// are undefined until loaded. the receiver cannot stall: each result is
// taken in the cycle it is shown.
`include "aabb_collision_side_resolver_macros.svh"

module aabb_collision_side_resolver
   import aabb_csr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [CNT_W-1:0] csr_wdata
);

   corner_type lower_mem [MAX_PLATFORMS];
   corner_type upper_mem [MAX_PLATFORMS];

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] limit_ff, limit_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   req_type          box_ff, box_in;

   logic             rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0] rd_idx_ff;
   corner_type       rd_lo_ff, rd_hi_ff;

   logic             s1_valid_ff, s1_valid_in;
   logic             s1_hit_ff, s1_hit_in;
   logic [IDX_W-1:0] s1_idx_ff;
   ovl_type          ov_left_ff, ov_right_ff, ov_top_ff, ov_bottom_ff;
   ovl_type          ov_left_in, ov_right_in, ov_top_in, ov_bottom_in;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             accept, accept_load, accept_query;
   logic             scanning, issue_more, hit_found, drained, finish;
   ovl_type          best_x, best_y;
   rsp_type          hit_rsp;

   logic             miss_shown, miss_clean, issue_legal;

   assign accept       = start && !busy;
   assign accept_load  = accept && (req_data.mode == MODE_LOAD);
   assign accept_query = accept && (req_data.mode == MODE_QUERY);

   assign hit_found = s1_valid_ff && s1_hit_ff;
   assign drained   = (issue_ff == limit_ff) && !rd_valid_ff && !s1_valid_ff;
   assign finish    = scanning && (hit_found || drained);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept_query) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit_found || drained) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      busy     = 1'b0;
      scanning = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
         end
         ST_SCAN: begin
            busy     = 1'b1;
            scanning = 1'b1;
         end
         default: busy = 1'b0;
      endcase
   end

   assign issue_more = scanning && (issue_ff < limit_ff) && !hit_found;

   always_comb begin
      count_in = csr_we ? csr_wdata : count_ff;
      limit_in = limit_ff;
      issue_in = issue_ff;
      box_in   = box_ff;
      if (accept_query) begin
         limit_in = (count_ff > CNT_W'(MAX_PLATFORMS)) ? CNT_W'(MAX_PLATFORMS) : count_ff;
         issue_in = '0;
         box_in   = req_data;
      end else if (issue_more) begin
         issue_in = issue_ff + CNT_W'(1);
      end
   end

   assign rd_valid_in = issue_more;
   assign s1_valid_in = rd_valid_ff && !finish;

   // compare stage
   always_comb begin
      s1_hit_in = (box_ff.box_min_x <= rd_hi_ff.x) && (box_ff.box_max_x >= rd_lo_ff.x) &&
                  (box_ff.box_min_y <= rd_hi_ff.y) && (box_ff.box_max_y >= rd_lo_ff.y);
      ov_left_in   = ovl_type'(rd_hi_ff.x) - ovl_type'(box_ff.box_min_x);
      ov_right_in  = ovl_type'(box_ff.box_max_x) - ovl_type'(rd_lo_ff.x);
      ov_top_in    = ovl_type'(rd_hi_ff.y) - ovl_type'(box_ff.box_min_y);
      ov_bottom_in = ovl_type'(box_ff.box_max_y) - ovl_type'(rd_lo_ff.y);
   end

   // select stage
   always_comb begin
      best_x = (ov_left_ff < ov_right_ff) ? ov_left_ff : ov_right_ff;
      best_y = (ov_top_ff < ov_bottom_ff) ? ov_top_ff : ov_bottom_ff;
      hit_rsp.hit_index = s1_idx_ff;
      if (best_x < best_y) begin
         if (ov_left_ff > ov_right_ff) begin
            hit_rsp.side    = SIDE_LEFT;
            hit_rsp.overlap = ov_right_ff[COORD_WIDTH-1:0];
         end else begin
            hit_rsp.side    = SIDE_RIGHT;
            hit_rsp.overlap = ov_left_ff[COORD_WIDTH-1:0];
         end
      end else begin
         if (ov_top_ff > ov_bottom_ff) begin
            hit_rsp.side    = SIDE_UP;
            hit_rsp.overlap = ov_bottom_ff[COORD_WIDTH-1:0];
         end else begin
            hit_rsp.side    = SIDE_DOWN;
            hit_rsp.overlap = ov_top_ff[COORD_WIDTH-1:0];
         end
      end
   end

   always_comb begin
      rsp_valid_in = finish;
      rsp_data_in  = rsp_data_ff;
      if (finish) begin
         if (hit_found) begin
            rsp_data_in = hit_rsp;
         end else begin
            rsp_data_in = '{side: SIDE_NONE, overlap: '0, hit_index: '0};
         end
      end
   end

   // corner memories
   always_ff @(posedge clock) begin
      if (accept_load && (MAX_PLATFORMS > int'(req_data.entry_index))) begin
         lower_mem[req_data.entry_index[IDX_W-1:0]] <=
            '{y: req_data.box_min_y, x: req_data.box_min_x};
         upper_mem[req_data.entry_index[IDX_W-1:0]] <=
            '{y: req_data.box_max_y, x: req_data.box_max_x};
      end
      rd_lo_ff <= lower_mem[issue_ff[IDX_W-1:0]];
      rd_hi_ff <= upper_mem[issue_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= '0;
         issue_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_valid_ff  <= rd_valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         limit_ff     <= limit_in;
         issue_ff     <= issue_in;
      end
   end

   always_ff @(posedge clock) begin
      box_ff       <= box_in;
      rd_idx_ff    <= issue_ff[IDX_W-1:0];
      s1_hit_ff    <= s1_hit_in;
      s1_idx_ff    <= rd_idx_ff;
      ov_left_ff   <= ov_left_in;
      ov_right_ff  <= ov_right_in;
      ov_top_ff    <= ov_top_in;
      ov_bottom_ff <= ov_bottom_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign miss_shown  = rsp_valid && (rsp_data.side == SIDE_NONE);
   assign miss_clean  = (rsp_data.overlap == '0) && (rsp_data.hit_index == '0);
   assign issue_legal = (issue_ff <= limit_ff) && (limit_ff <= CNT_W'(MAX_PLATFORMS));

   `AABB_ASSERT_SAME(a_rsp_when_idle, clock, reset, rsp_valid, !busy, "result during scan")
   `AABB_ASSERT_NEXT(a_query_busy, clock, reset, accept_query, busy, "query not scanning")
   `AABB_ASSERT_SAME(a_miss_zero, clock, reset, miss_shown, miss_clean, "miss fields nonzero")
   `AABB_ASSERT_SAME(a_issue_bound, clock, reset, busy, issue_legal, "scan past count")

endmodule

/* verif/aabb_collision_side_resolver_tb.sv */
`timescale 1ns / 1ps

module aabb_collision_side_resolver_tb;
   import aabb_csr_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   req_type          req_data = '0;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_we = 1'b0;
   logic [CNT_W-1:0] csr_wdata = '0;

   aabb_collision_side_resolver dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   req_type    pending_items[$];
   rsp_type    expected_contacts[$];
   corner_type platform_lo [MAX_PLATFORMS];
   corner_type platform_hi [MAX_PLATFORMS];
   int         scan_count = 0;
   int         idle_pct = 29;
   logic       drain_hold = 1'b0;
   int         mismatches = 0;
   int         cycles = 0;
   int         scene_x, scene_y, scene_span;

   function automatic rsp_type resolve_contact(req_type q);
      int n, bx0, by0, bx1, by1, lx, ly, hx, hy;
      int ov_left, ov_right, ov_top, ov_bottom, best_x, best_y, amount;
      rsp_type r;
      bit found;
      r.side = SIDE_NONE;
      r.overlap = '0;
      r.hit_index = '0;
      found = 1'b0;
      n = (scan_count > MAX_PLATFORMS) ? MAX_PLATFORMS : scan_count;
      bx0 = $signed(q.box_min_x);
      by0 = $signed(q.box_min_y);
      bx1 = $signed(q.box_max_x);
      by1 = $signed(q.box_max_y);
      for (int i = 0; i < n && !found; i++) begin
         lx = $signed(platform_lo[i].x);
         ly = $signed(platform_lo[i].y);
         hx = $signed(platform_hi[i].x);
         hy = $signed(platform_hi[i].y);
         if (bx0 <= hx && bx1 >= lx && by0 <= hy && by1 >= ly) begin
            found = 1'b1;
            ov_left = hx - bx0;
            ov_right = bx1 - lx;
            ov_top = hy - by0;
            ov_bottom = by1 - ly;
            best_x = (ov_left < ov_right) ? ov_left : ov_right;
            best_y = (ov_top < ov_bottom) ? ov_top : ov_bottom;
            if (best_x < best_y) begin
               if (ov_left > ov_right) begin
                  r.side = SIDE_LEFT;
                  amount = ov_right;
               end else begin
                  r.side = SIDE_RIGHT;
                  amount = ov_left;
               end
            end else begin
               if (ov_top > ov_bottom) begin
                  r.side = SIDE_UP;
                  amount = ov_bottom;
               end else begin
                  r.side = SIDE_DOWN;
                  amount = ov_top;
               end
            end
            r.overlap = amount[15:0];
            r.hit_index = i[5:0];
         end
      end
      return r;
   endfunction

   task automatic record_item(req_type q);
      if (q.mode == MODE_LOAD) begin
         platform_lo[q.entry_index] = '{y: q.box_min_y, x: q.box_min_x};
         platform_hi[q.entry_index] = '{y: q.box_max_y, x: q.box_max_x};
      end else begin
         expected_contacts.push_back(resolve_contact(q));
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         drain_hold <= 1'b0;
      end else begin
         if (start && !busy) record_item(req_data);
         if (!start || !busy) begin
            if (drain_hold) begin
               start <= 1'b0;
               if (expected_contacts.size() == 0) drain_hold <= 1'b0;
            end else if (pending_items.size() == 0 || $urandom_range(99) < idle_pct) begin
               start <= 1'b0;
            end else if ($urandom_range(99) == 0) begin
               start <= 1'b0;
               drain_hold <= 1'b1;
            end else begin
               start <= 1'b1;
               req_data <= pending_items.pop_front();
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_contacts.size() == 0) begin
            mismatches++;
            $display("%0t result expected none actual side=%0d overlap=%0d hit_index=%0d",
                     $time, rsp_data.side, rsp_data.overlap, rsp_data.hit_index);
         end else begin
            want = expected_contacts.pop_front();
            if (rsp_data.side !== want.side) begin
               mismatches++;
               $display("%0t side expected %0d actual %0d", $time, want.side, rsp_data.side);
            end
            if (rsp_data.overlap !== want.overlap) begin
               mismatches++;
               $display("%0t overlap expected %0d actual %0d", $time, want.overlap,
                        rsp_data.overlap);
            end
            if (rsp_data.hit_index !== want.hit_index) begin
               mismatches++;
               $display("%0t hit_index expected %0d actual %0d", $time, want.hit_index,
                        rsp_data.hit_index);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic push_item(mode_type m, int idx, int x0, int y0, int x1, int y1);
      req_type q;
      q.mode = m;
      q.entry_index = idx[5:0];
      q.box_min_x = x0[15:0];
      q.box_min_y = y0[15:0];
      q.box_max_x = x1[15:0];
      q.box_max_y = y1[15:0];
      pending_items.push_back(q);
   endtask

   task automatic push_noise();
      req_type q;
      q.mode = mode_type'($urandom_range(1));
      q.entry_index = 6'($urandom_range(63));
      q.box_min_x = 16'($urandom);
      q.box_min_y = 16'($urandom);
      q.box_max_x = 16'($urandom);
      q.box_max_y = 16'($urandom);
      pending_items.push_back(q);
   endtask

   // box somewhere in the current scene, now and then inverted
   task automatic push_scene_box(mode_type m, int idx);
      int x0, y0, x1, y1, tmp;
      x0 = scene_x + $urandom_range(scene_span);
      y0 = scene_y + $urandom_range(scene_span);
      x1 = x0 + $urandom_range(m == MODE_LOAD ? 320 : 160);
      y1 = y0 + $urandom_range(m == MODE_LOAD ? 320 : 160);
      if ($urandom_range(19) == 0) begin
         tmp = x0;
         x0 = x1;
         x1 = tmp;
      end
      if ($urandom_range(19) == 0) begin
         tmp = y0;
         y0 = y1;
         y1 = tmp;
      end
      push_item(m, idx, x0, y0, x1, y1);
   endtask

   task automatic new_scene();
      scene_x = int'($urandom_range(60000)) - 30000;
      scene_y = int'($urandom_range(60000)) - 30000;
      scene_span = $urandom_range(1, 8) * 256;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_items.size() != 0 || start || busy || drain_hold ||
             expected_contacts.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_platform_count(int v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v[CNT_W-1:0];
      scan_count = v & 7'h7f;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int slots [64];
      int j, tmp, r, cnt;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty table: count zero never hits
      push_item(MODE_QUERY, 63, -32768, -32768, -32768, -32768);
      push_item(MODE_QUERY, 0, 32767, 32767, 32767, 32767);
      push_item(MODE_LOAD, 0, 0, 0, 160, 160);
      push_item(MODE_LOAD, 1, -32768, -32768, -32700, -32700);
      push_item(MODE_LOAD, 2, 32700, 32700, 32767, 32767);
      push_item(MODE_LOAD, 3, 500, 500, 400, 600);
      push_item(MODE_LOAD, 4, 1000, 1000, 2000, 2000);
      push_item(MODE_LOAD, 5, -32768, 20000, 32767, 20100);
      push_item(MODE_QUERY, 5, 0, 0, 0, 0);
      wait_drained();
      write_platform_count(6);

      push_item(MODE_QUERY, 0, 150, 20, 300, 140);
      push_item(MODE_QUERY, 0, -100, 20, 5, 140);
      push_item(MODE_QUERY, 0, 20, 150, 140, 300);
      push_item(MODE_QUERY, 0, 20, -100, 140, 5);
      // equal overlaps go to the y axis
      push_item(MODE_QUERY, 0, 150, 150, 300, 300);
      push_item(MODE_QUERY, 0, 160, 50, 200, 60);
      push_item(MODE_QUERY, 0, 100, 100, 50, 50);
      push_item(MODE_QUERY, 0, -32768, -32768, -32768, -32768);
      push_item(MODE_QUERY, 0, 32767, 32767, 32767, 32767);
      push_item(MODE_QUERY, 0, -32768, -32768, 32767, 32767);
      push_item(MODE_QUERY, 0, 300, 550, 600, 550);
      push_item(MODE_QUERY, 0, 5000, 20050, 5000, 20050);
      push_item(MODE_QUERY, 63, 0, 10000, 0, 10000);
      wait_drained();

      // fill every slot in shuffled order with queries in between
      new_scene();
      for (int i = 0; i < 64; i++) slots[i] = i;
      for (int i = 63; i > 0; i--) begin
         j = $urandom_range(i);
         tmp = slots[i];
         slots[i] = slots[j];
         slots[j] = tmp;
      end
      for (int i = 0; i < 64; i++) begin
         push_scene_box(MODE_LOAD, slots[i]);
         if ($urandom_range(1) == 0) push_scene_box(MODE_QUERY, 0);
      end
      wait_drained();

      for (int p = 0; p < 12; p++) begin
         idle_pct = (p < 4) ? 29 : (p < 8) ? 64 : 0;
         case (p)
            0: cnt = 64;
            1: cnt = 127;
            2: cnt = 1;
            3: cnt = 0;
            4: cnt = 65;
            5: cnt = 32;
            6: cnt = 64;
            default: cnt = $urandom_range(127);
         endcase
         write_platform_count(cnt);
         new_scene();
         for (int k = 0; k < 125; k++) begin
            r = $urandom_range(99);
            if (r < 8) push_noise();
            else if (r < 33) push_scene_box(MODE_LOAD, $urandom_range(63));
            else push_scene_box(MODE_QUERY, $urandom_range(63));
         end
         wait_drained();
      end

      repeat (70) @(posedge clock);
      if (expected_contacts.size() != 0) begin
         mismatches++;
         $display("%0t results outstanding expected 0 actual %0d", $time,
                  expected_contacts.size());
      end
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
